// ===== sv/dbps_pkg.sv =====
// dbps_pkg: shared types, fixed-point constants and helper functions
// for the drag ballistic pitch solver; no dependencies
package dbps_pkg;

    // datapath word widths
    localparam int HW = 48;            // saturated height word, Q16.16
    localparam int AW = 33;            // angle word, Q2.30
    localparam int CW = 50;            // cordic x / y word
    localparam int MW = 35;            // multiplier operand
    localparam int PW = 2 * MW;        // multiplier product

    // shared divider geometry
    localparam int DIV_NUM_W  = 54;
    localparam int DIV_DEN_W  = 40;
    localparam int DIV_SH_W   = 5;
    localparam int DIV_SH_MAX = 30;
    localparam int DIV_Q_W    = 47;

    localparam int MAX_ITER_DEF = 100;
    localparam int CORDIC_N     = 30;
    localparam int SERIES_TERMS = 13;

    // fixed-point constants
    localparam logic signed [HW-1:0] SAT_LIM   = 48'sh4000_0000_0000;
    localparam logic signed [HW+1:0] SAT_WIDE  = 50'sh4000_0000_0000;
    localparam logic signed [CW-1:0] SCALE_TOP = 50'sh2000_0000_0000;
    localparam logic signed [CW-1:0] CORDIC_K  = 50'sd652032874;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [30:0] HALF_Q30  = 31'h2000_0000;
    localparam logic [30:0] TEMP_MAX  = 31'd1072668082;
    localparam logic [31:0] COS_MIN   = 32'd1074;
    localparam logic [21:0] DIST_MIN  = 22'd66;
    localparam logic [33:0] LN2_Q30   = 34'd744261118;
    localparam logic [23:0] FT_MAX    = 24'hFF_FFFF;
    localparam logic signed [AW:0] PITCH_RND = 34'sd8192;

    // register indexes on the configuration port
    localparam logic [1:0] REG_DRAG_COEFF = 2'd0;
    localparam logic [1:0] REG_GRAVITY    = 2'd1;
    localparam logic [1:0] REG_MUZZLE     = 2'd2;
    localparam logic [1:0] REG_TOLERANCE  = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE, S_KV, S_KK, S_INIT,
        S_AT_LOAD, S_AT_NORM, S_CORDIC, S_AT_DONE,
        S_SC_LOAD, S_SC_DONE,
        S_DR_MUL, S_DR_DIV1, S_DR_DIV2, S_DR_CAP,
        S_LN_INIT, S_LN_NORM, S_LN_UDIV, S_LN_SQ, S_LN_U2,
        S_LN_TERM, S_LN_ACC, S_LN_NEXT, S_LN_DONE,
        S_T1_MUL, S_T1_DIV, S_T2_MUL, S_T2_DIV1, S_T2_DIV2,
        S_T3_MUL, S_T3_DIV,
        S_PASS_Z, S_PASS_D, S_PASS_ZL,
        S_FT_DIV, S_OUT
    } state_t;

    // divider request and response
    typedef struct packed {
        logic                 start;
        logic                 neg;
        logic [DIV_SH_W-1:0]  sh;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_Q_W:0]   quo;
    } div_rsp_t;

    // saturate a widened value to +-2^46
    function automatic logic signed [HW-1:0] sat_h(input logic signed [HW+1:0] v);
        logic signed [HW-1:0] r;
        if (v > SAT_WIDE)
        begin
            r = SAT_LIM;
        end
        else if (v < -SAT_WIDE)
        begin
            r = -SAT_LIM;
        end
        else
        begin
            r = v[HW-1:0];
        end
        return r;
    endfunction

    // arctangent of 2^-i, Q2.30
    function automatic logic signed [AW-1:0] atan_entry(input logic [4:0] i);
        logic [29:0] t;
        case (i)
            5'd0:    t = 30'd843314857;
            5'd1:    t = 30'd497837829;
            5'd2:    t = 30'd263043837;
            5'd3:    t = 30'd133525159;
            5'd4:    t = 30'd67021687;
            5'd5:    t = 30'd33543516;
            5'd6:    t = 30'd16775851;
            5'd7:    t = 30'd8388437;
            5'd8:    t = 30'd4194283;
            5'd9:    t = 30'd2097149;
            5'd10:   t = 30'd1048576;
            5'd11:   t = 30'd524288;
            5'd12:   t = 30'd262144;
            5'd13:   t = 30'd131072;
            5'd14:   t = 30'd65536;
            5'd15:   t = 30'd32768;
            5'd16:   t = 30'd16384;
            5'd17:   t = 30'd8192;
            5'd18:   t = 30'd4096;
            5'd19:   t = 30'd2048;
            5'd20:   t = 30'd1024;
            5'd21:   t = 30'd512;
            5'd22:   t = 30'd256;
            5'd23:   t = 30'd128;
            5'd24:   t = 30'd64;
            5'd25:   t = 30'd32;
            5'd26:   t = 30'd16;
            5'd27:   t = 30'd8;
            5'd28:   t = 30'd4;
            5'd29:   t = 30'd2;
            default: t = 30'd0;
        endcase
        return AW'(t);
    endfunction

endpackage

// ===== sv/drag_ballistic_pitch_solver_unit.sv =====
// drag_ballistic_pitch_solver_unit: top level of the linear-drag pitch solver
// depends on dbps_pkg and dbps_div
//
// usage
//   input channel in_valid/in_ready carries distance and height (Q16.16);
//   output channel out_valid/out_ready carries pitch_angle, flight_time and
//   iterations. configuration is a plain write port (cfg_write, cfg_index,
//   cfg_data) taking drag_coeff, gravity_accel, muzzle_speed and
//   height_tolerance at indexes 0..3, to be written by the user only while
//   the block is idle; the block does not enforce this. one item is in
//   flight at a time; in_ready is high only while idle. each pass runs a
//   vectoring cordic (normalize shifts plus 30 steps), a rotation cordic
//   (30) and a log series; its twenty divisions (seventeen on the final
//   pass) run on one shared restoring divider, with one shared multiplier;
//   an item takes passes+1 such rounds.
//   the finished result sits in an output register; a new item is accepted
//   while it waits, and the solver holds its next result until the receiver
//   has taken the previous one.
//   reset returns the sequencer to idle, drops out_valid and loads the
//   register defaults.
module drag_ballistic_pitch_solver_unit
    import dbps_pkg::*;
#(
    parameter int MAX_ITER = MAX_ITER_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [21:0]        distance,
    input  logic signed [20:0] height,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [17:0] pitch_angle,
    output logic [23:0]        flight_time,
    output logic [6:0]         iterations,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [22:0]        cfg_data
);

    localparam int NCW = $clog2(MAX_ITER + 1);

    // configuration registers
    logic [16:0] kf_reg, tol_reg;
    logic [20:0] g_reg;
    logic [22:0] v_reg;
    logic [16:0] kf_eff;
    logic [22:0] v_eff;

    // sequencer
    state_t           state_reg, state_next;
    logic             dwait_reg;
    logic [NCW-1:0]   n_reg;
    logic             final_reg;
    logic             out_valid_reg;

    // datapath registers
    logic [21:0]             d_reg;
    logic signed [20:0]      h_reg;
    logic signed [HW-1:0]    zl_reg, diff_reg;
    logic signed [HW+1:0]    acc_reg;
    logic signed [AW-1:0]    beta_reg, cz_reg, s_reg;
    logic signed [CW-1:0]    cx_reg, cy_reg;
    logic [4:0]              ci_reg;
    logic                    rot_reg, aneg_reg;
    logic [31:0]             c_reg;
    logic [30:0]             temp_reg, lx_reg, sum_reg;
    logic [33:0]             lnk_reg, nl_reg, kk_reg;
    logic [29:0]             u2_reg, p_reg;
    logic [3:0]              j_reg;
    logic [39:0]             kfv_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [17:0]      pitch_reg;
    logic [23:0]             ft_reg;
    logic [6:0]              iter_reg;

    // combinational
    div_req_t                div_req;
    div_rsp_t                div_rsp;
    logic signed [DIV_Q_W:0] quo;
    logic [PW-1:0]           prod_abs;
    logic [HW-1:0]           zl_abs, diff_abs;
    logic signed [MW-1:0]    mul_a, mul_b;
    logic                    is_div, out_load, cont, norm_go;
    logic signed [CW-1:0]    xsh, ysh, cx_step, cy_step;
    logic signed [AW-1:0]    tab, cz_step;
    logic                    plus;
    logic signed [AW:0]      pitch_sum;

    assign kf_eff   = (kf_reg == '0) ? 17'd1 : kf_reg;
    assign v_eff    = (v_reg == '0) ? 23'd1 : v_reg;
    assign quo      = $signed(div_rsp.quo);
    assign prod_abs = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
    assign zl_abs   = zl_reg[HW-1] ? HW'(-zl_reg) : HW'(zl_reg);
    assign diff_abs = diff_reg[HW-1] ? HW'(-diff_reg) : HW'(diff_reg);
    assign cont     = (diff_abs >= HW'(tol_reg)) && (int'(n_reg) < MAX_ITER);
    assign norm_go  = (cx_reg < SCALE_TOP) && (cy_reg < SCALE_TOP);

    // shared cordic step
    assign xsh     = cx_reg >>> ci_reg;
    assign ysh     = cy_reg >>> ci_reg;
    assign tab     = atan_entry(ci_reg);
    assign plus    = rot_reg ? cz_reg[AW-1] : (cy_reg > 0);
    assign cx_step = plus ? cx_reg + ysh : cx_reg - ysh;
    assign cy_step = plus ? cy_reg - xsh : cy_reg + xsh;
    assign cz_step = plus ? cz_reg + tab : cz_reg - tab;

    assign pitch_sum = (AW+1)'(beta_reg) + PITCH_RND;

    dbps_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kf_reg  <= 17'd6554;
            g_reg   <= 21'd642252;
            v_reg   <= 23'd1572864;
            tol_reg <= 17'd7;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DRAG_COEFF: kf_reg  <= cfg_data[16:0];
                REG_GRAVITY:    g_reg   <= cfg_data[20:0];
                REG_MUZZLE:     v_reg   <= cfg_data[22:0];
                REG_TOLERANCE:  tol_reg <= cfg_data[16:0];
                default:        ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_KV;
            S_KV:      state_next = S_KK;
            S_KK:      state_next = S_INIT;
            S_INIT:    state_next = S_AT_LOAD;
            S_AT_LOAD: state_next = S_AT_NORM;
            S_AT_NORM: if (!norm_go) state_next = S_CORDIC;
            S_CORDIC:
            begin
                if (ci_reg == 5'(CORDIC_N - 1))
                begin
                    state_next = rot_reg ? S_SC_DONE : S_AT_DONE;
                end
            end
            S_AT_DONE: state_next = S_SC_LOAD;
            S_SC_LOAD: state_next = S_CORDIC;
            S_SC_DONE: state_next = S_DR_MUL;
            S_DR_MUL:  state_next = S_DR_DIV1;
            S_DR_DIV1: if (dwait_reg && div_rsp.done) state_next = S_DR_DIV2;
            S_DR_DIV2: if (dwait_reg && div_rsp.done) state_next = S_DR_CAP;
            S_DR_CAP:  state_next = S_LN_INIT;
            S_LN_INIT: state_next = S_LN_NORM;
            S_LN_NORM: if (lx_reg >= HALF_Q30) state_next = S_LN_UDIV;
            S_LN_UDIV: if (dwait_reg && div_rsp.done) state_next = S_LN_SQ;
            S_LN_SQ:   state_next = S_LN_U2;
            S_LN_U2:   state_next = S_LN_TERM;
            S_LN_TERM: if (dwait_reg && div_rsp.done) state_next = S_LN_ACC;
            S_LN_ACC:  state_next = S_LN_NEXT;
            S_LN_NEXT:
            begin
                state_next = (j_reg == 4'(SERIES_TERMS - 1)) ? S_LN_DONE : S_LN_TERM;
            end
            S_LN_DONE: state_next = final_reg ? S_FT_DIV : S_T1_MUL;
            S_T1_MUL:  state_next = S_T1_DIV;
            S_T1_DIV:  if (dwait_reg && div_rsp.done) state_next = S_T2_MUL;
            S_T2_MUL:  state_next = S_T2_DIV1;
            S_T2_DIV1: if (dwait_reg && div_rsp.done) state_next = S_T2_DIV2;
            S_T2_DIV2: if (dwait_reg && div_rsp.done) state_next = S_T3_MUL;
            S_T3_MUL:  state_next = S_T3_DIV;
            S_T3_DIV:  if (dwait_reg && div_rsp.done) state_next = S_PASS_Z;
            S_PASS_Z:  state_next = S_PASS_D;
            S_PASS_D:  state_next = S_PASS_ZL;
            S_PASS_ZL: state_next = S_AT_LOAD;
            S_FT_DIV:  if (dwait_reg && div_rsp.done) state_next = S_OUT;
            S_OUT:     if (out_load) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // sequencer outputs: handshakes, multiplier and divider operands
    always_comb
    begin
        in_ready    = (state_reg == S_IDLE);
        out_load    = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
        is_div      = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        div_req.neg = 1'b0;
        div_req.sh  = '0;
        div_req.num = '0;
        div_req.den = DIV_DEN_W'(1);
        case (state_reg)
            S_KV:
            begin
                mul_a = MW'(kf_eff);
                mul_b = MW'(v_eff);
            end
            S_KK:
            begin
                mul_a = MW'(kf_eff);
                mul_b = MW'(kf_eff);
            end
            S_DR_MUL:
            begin
                mul_a = MW'(d_reg);
                mul_b = MW'(kf_eff);
            end
            S_DR_DIV1:
            begin
                is_div      = 1'b1;
                div_req.sh  = 5'd14;
                div_req.num = prod_abs[DIV_NUM_W-1:0];
                div_req.den = DIV_DEN_W'(v_eff);
            end
            S_DR_DIV2, S_T2_DIV2:
            begin
                is_div      = 1'b1;
                div_req.sh  = 5'd30;
                div_req.num = DIV_NUM_W'(quo[DIV_Q_W-1:0]);
                div_req.den = DIV_DEN_W'(c_reg);
            end
            S_LN_UDIV:
            begin
                is_div      = 1'b1;
                div_req.sh  = 5'd30;
                div_req.num = DIV_NUM_W'(ONE_Q30 - lx_reg);
                div_req.den = DIV_DEN_W'({1'b0, ONE_Q30} + {1'b0, lx_reg});
            end
            S_LN_SQ:
            begin
                mul_a = MW'(quo[29:0]);
                mul_b = MW'(quo[29:0]);
            end
            S_LN_TERM:
            begin
                is_div      = 1'b1;
                div_req.num = DIV_NUM_W'(p_reg);
                div_req.den = DIV_DEN_W'({j_reg, 1'b1});
            end
            S_LN_ACC:
            begin
                mul_a = MW'(p_reg);
                mul_b = MW'(u2_reg);
            end
            S_T1_MUL:
            begin
                mul_a = MW'(d_reg);
                mul_b = MW'(s_reg);
            end
            S_T1_DIV:
            begin
                is_div      = 1'b1;
                div_req.neg = prod_reg[PW-1];
                div_req.num = prod_abs[DIV_NUM_W-1:0];
                div_req.den = DIV_DEN_W'(c_reg);
            end
            S_T2_MUL:
            begin
                mul_a = MW'(d_reg);
                mul_b = MW'(g_reg);
            end
            S_T2_DIV1:
            begin
                is_div      = 1'b1;
                div_req.sh  = 5'd16;
                div_req.num = prod_abs[DIV_NUM_W-1:0];
                div_req.den = kfv_reg;
            end
            S_T3_MUL:
            begin
                mul_a = MW'(g_reg);
                mul_b = MW'(nl_reg);
            end
            S_T3_DIV:
            begin
                is_div      = 1'b1;
                div_req.sh  = 5'd2;
                div_req.num = prod_abs[DIV_NUM_W-1:0];
                div_req.den = DIV_DEN_W'(kk_reg);
            end
            S_FT_DIV:
            begin
                is_div      = 1'b1;
                div_req.sh  = 5'd2;
                div_req.num = DIV_NUM_W'(nl_reg);
                div_req.den = DIV_DEN_W'(kf_eff);
            end
            default: ;
        endcase
        div_req.start = is_div && !dwait_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dwait_reg     <= 1'b0;
            n_reg         <= '0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_req.start)
            begin
                dwait_reg <= 1'b1;
            end
            else if (div_rsp.done)
            begin
                dwait_reg <= 1'b0;
            end
            if (state_reg == S_IDLE && in_valid)
            begin
                n_reg     <= '0;
                final_reg <= 1'b0;
            end
            else if (state_reg == S_PASS_Z)
            begin
                n_reg <= n_reg + 1'b1;
            end
            else if (state_reg == S_PASS_ZL)
            begin
                final_reg <= !cont;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // shared multiplier, registered product
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    d_reg <= (distance < DIST_MIN) ? DIST_MIN : distance;
                    h_reg <= height;
                end
            end
            S_KK:      kfv_reg <= prod_reg[39:0];
            S_INIT:
            begin
                kk_reg <= prod_reg[33:0];
                zl_reg <= HW'(h_reg);
            end
            S_AT_LOAD:
            begin
                cx_reg   <= CW'(d_reg);
                cy_reg   <= CW'(zl_abs);
                cz_reg   <= '0;
                aneg_reg <= zl_reg[HW-1];
            end
            S_AT_NORM:
            begin
                if (norm_go)
                begin
                    cx_reg <= cx_reg <<< 1;
                    cy_reg <= cy_reg <<< 1;
                end
                else
                begin
                    ci_reg  <= '0;
                    rot_reg <= 1'b0;
                end
            end
            S_CORDIC:
            begin
                cx_reg <= cx_step;
                cy_reg <= cy_step;
                cz_reg <= cz_step;
                ci_reg <= ci_reg + 1'b1;
            end
            S_AT_DONE: beta_reg <= aneg_reg ? -cz_reg : cz_reg;
            S_SC_LOAD:
            begin
                cx_reg  <= CORDIC_K;
                cy_reg  <= '0;
                cz_reg  <= beta_reg;
                ci_reg  <= '0;
                rot_reg <= 1'b1;
            end
            S_SC_DONE:
            begin
                c_reg <= (cx_reg < CW'(COS_MIN)) ? COS_MIN : cx_reg[31:0];
                s_reg <= cy_reg[AW-1:0];
            end
            S_DR_CAP:
            begin
                temp_reg <= (quo > (DIV_Q_W+1)'(TEMP_MAX)) ? TEMP_MAX : quo[30:0];
            end
            S_LN_INIT:
            begin
                lx_reg  <= ONE_Q30 - temp_reg;
                lnk_reg <= '0;
            end
            S_LN_NORM:
            begin
                if (lx_reg < HALF_Q30)
                begin
                    lx_reg  <= lx_reg << 1;
                    lnk_reg <= lnk_reg + LN2_Q30;
                end
            end
            S_LN_SQ:   p_reg <= quo[29:0];
            S_LN_U2:
            begin
                u2_reg  <= prod_reg[59:30];
                sum_reg <= '0;
                j_reg   <= '0;
            end
            S_LN_ACC:  sum_reg <= sum_reg + quo[30:0];
            S_LN_NEXT:
            begin
                p_reg <= prod_reg[59:30];
                j_reg <= j_reg + 1'b1;
            end
            S_LN_DONE: nl_reg <= 34'({sum_reg, 1'b0}) + lnk_reg;
            S_T2_MUL:  acc_reg <= (HW+2)'(quo);
            S_T3_MUL:  acc_reg <= acc_reg + (HW+2)'(quo);
            S_PASS_Z:  acc_reg <= (HW+2)'(sat_h(acc_reg - (HW+2)'(quo)));
            S_PASS_D:  diff_reg <= sat_h(acc_reg - (HW+2)'(h_reg));
            S_PASS_ZL: zl_reg <= sat_h((HW+2)'(zl_reg) - (HW+2)'(diff_reg));
            S_OUT:
            begin
                if (out_load)
                begin
                    pitch_reg <= pitch_sum[31:14];
                    ft_reg    <= (quo > (DIV_Q_W+1)'(FT_MAX)) ? FT_MAX : quo[23:0];
                    iter_reg  <= (int'(n_reg) > 127) ? 7'd127 : 7'(n_reg);
                end
            end
            default: ;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign pitch_angle = pitch_reg;
    assign flight_time = ft_reg;
    assign iterations  = iter_reg;

`ifndef SYNTHESIS
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> dwait_reg)
        else $error("divider finished with no request outstanding");
    a_iter_max: assert property (@(posedge clk) disable iff (!rst_n)
        int'(n_reg) <= MAX_ITER)
        else $error("pass count beyond limit");
    a_out_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (final_reg && n_reg != '0))
        else $error("result loaded before the final pass");
`endif

endmodule

// ===== sv/dbps_div.sv =====
// dbps_div: restoring divider, one quotient bit per cycle, result
// truncated toward zero and saturated to 2^46; uses dbps_pkg
module dbps_div
    import dbps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int NW    = DIV_NUM_W + DIV_SH_MAX;
    localparam int CNT_W = $clog2(DIV_Q_W + 1);
    localparam logic [DIV_Q_W-1:0] QSAT = {1'b1, {(DIV_Q_W-1){1'b0}}};

    logic                   busy_reg, done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [DIV_DEN_W-1:0]   rem_reg, den_reg, rem_next;
    logic [DIV_Q_W-1:0]     low_reg, q_reg, q_next, mag;
    logic                   neg_reg;
    logic [DIV_Q_W:0]       res_reg;

    logic [NW-1:0]          nfull;
    logic [NW-DIV_Q_W-1:0]  hi;
    logic                   pre_sat;
    logic [DIV_DEN_W:0]     trial, trial_sub;
    logic                   ge;

    // scaled numerator and overflow precheck
    assign nfull   = NW'(req.num) << req.sh;
    assign hi      = nfull[NW-1:DIV_Q_W];
    assign pre_sat = DIV_DEN_W'(hi) >= req.den;

    // one restoring step
    assign trial     = {rem_reg, low_reg[DIV_Q_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign ge        = trial >= {1'b0, den_reg};
    assign rem_next  = ge ? trial_sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    assign q_next    = {q_reg[DIV_Q_W-2:0], ge};
    assign mag       = (q_next > QSAT) ? QSAT : q_next;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= !pre_sat;
            done_reg <= pre_sat;
            cnt_reg  <= CNT_W'(DIV_Q_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= DIV_DEN_W'(hi);
            low_reg <= nfull[DIV_Q_W-1:0];
            q_reg   <= '0;
            den_reg <= req.den;
            neg_reg <= req.neg;
            if (pre_sat)
            begin
                res_reg <= req.neg ? -{1'b0, QSAT} : {1'b0, QSAT};
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[DIV_Q_W-2:0], 1'b0};
            q_reg   <= q_next;
            if (cnt_reg == CNT_W'(1))
            begin
                res_reg <= neg_reg ? -{1'b0, mag} : {1'b0, mag};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = res_reg;

endmodule
